// ----- src/fupd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fupd_pkg
// shared types, constants and character helpers of the file uri decoder
// ----------------------------------------------------------------------------
package fupd_pkg;

    localparam int unsigned PREFIX_LEN = 7;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_LOW_A   = 8'h61;
    localparam logic [7:0] CHAR_LOW_F   = 8'h66;
    localparam logic [7:0] CHAR_LOW_Z   = 8'h7a;
    localparam logic [7:0] CHAR_UP_A    = 8'h41;
    localparam logic [7:0] CHAR_UP_F    = 8'h46;
    localparam logic [7:0] CHAR_UP_Z    = 8'h5a;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;
    localparam logic [7:0] HEX_TEN      = 8'd10;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_PROTO = 2'd1,
        ST_ENC   = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       done_res;
        t_status    status;
    } t_res;

    typedef struct packed {
        logic byte_en;
        t_res byte_res;
        logic done_en;
        t_res done_item;
    } t_step;

    // expected character of "file://" at a position
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h66;
            3'd1:    c = 8'h69;
            3'd2:    c = 8'h6c;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h3a;
            3'd5:    c = 8'h2f;
            3'd6:    c = 8'h2f;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

    // bit 4 flags a valid hex digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        d = 8'd0;
        r = 5'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - CHAR_ZERO;
            r = {1'b1, d[3:0]};
        end else if (c >= CHAR_LOW_A && c <= CHAR_LOW_F) begin
            d = c - CHAR_LOW_A + HEX_TEN;
            r = {1'b1, d[3:0]};
        end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
            d = c - CHAR_UP_A + HEX_TEN;
            r = {1'b1, d[3:0]};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/file_uri_percent_decoder_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// file_uri_percent_decoder_unit
// checks the "file://" prefix and decodes percent escapes of a byte stream
// ----------------------------------------------------------------------------
// an accepted beat is registered, then decoded into a four-entry result queue
// throughput: one input beat per cycle while the queue has room; a final beat
//   that also decodes a byte yields two results, drained one per cycle while ready
// input accept is held off only while that queue has fewer than two free slots
// reset: synchronous active low, returns to prefix check and empties the queue
// ----------------------------------------------------------------------------
module file_uri_percent_decoder_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // in_byte
    input  wire logic        i_s_axis_tlast,   // end_of_text
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // out_byte[7:0], status[9:8], zeros
    output logic             o_m_axis_tlast,   // done_res
    output logic             o_m_axis_tuser    // byte_valid
);
    import fupd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       room;
    logic       commit;
    t_step      step;
    t_res       res;

    assign commit          = r_in_valid && room;
    assign o_s_axis_tready = !r_in_valid || commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    fupd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (commit),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_step   (step)
    );

    fupd_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (commit),
        .i_step  (step),
        .o_room  (room),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (res)
    );

    assign o_m_axis_tdata = {6'd0, res.status, res.out_byte};
    assign o_m_axis_tlast = res.done_res;
    assign o_m_axis_tuser = res.byte_valid;

endmodule
`default_nettype wire

// ----- src/fupd_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fupd_core
// decode state and per-beat step logic: prefix check, escape decode, status
// ----------------------------------------------------------------------------
module fupd_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_commit,
    input  wire logic [7:0]     i_byte,
    input  wire logic           i_last,
    output fupd_pkg::t_step     o_step
);
    import fupd_pkg::*;

    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_PLAIN  = 2'd1,
        PH_HIGH   = 2'd2,
        PH_LOW    = 2'd3
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [2:0] r_pos, n_pos;
    logic [3:0] r_high, n_high;
    t_status    r_err, n_err;
    logic [4:0] hex;
    t_status    fin;

    always_comb begin
        hex     = hex_value(i_byte);
        n_phase = r_phase;
        n_pos   = r_pos;
        n_high  = r_high;
        n_err   = r_err;
        o_step  = '0;
        o_step.byte_res.byte_valid = 1'b1;
        o_step.byte_res.status     = ST_OK;
        o_step.done_item.done_res  = 1'b1;
        if (r_err == ST_OK) begin
            case (r_phase)
                PH_PREFIX: begin
                    if (r_pos >= 3'(PREFIX_LEN) || fold_case(i_byte) != prefix_char(r_pos)) begin
                        n_err = ST_PROTO;
                    end else begin
                        n_pos = r_pos + 3'd1;
                        if (n_pos == 3'(PREFIX_LEN)) begin
                            n_phase = PH_PLAIN;
                        end
                    end
                end
                PH_PLAIN: begin
                    if (i_byte == CHAR_PERCENT) begin
                        n_phase = PH_HIGH;
                    end else begin
                        o_step.byte_en           = 1'b1;
                        o_step.byte_res.out_byte = i_byte;
                    end
                end
                PH_HIGH: begin
                    if (!hex[4]) begin
                        n_err = ST_ENC;
                    end else begin
                        n_high  = hex[3:0];
                        n_phase = PH_LOW;
                    end
                end
                default: begin
                    if (!hex[4]) begin
                        n_err = ST_ENC;
                    end else begin
                        o_step.byte_en           = 1'b1;
                        o_step.byte_res.out_byte = {r_high, hex[3:0]};
                        n_phase                  = PH_PLAIN;
                    end
                end
            endcase
        end
        fin = n_err;
        if (n_err == ST_OK) begin
            case (n_phase)
                PH_PREFIX: fin = ST_PROTO;
                PH_HIGH:   fin = ST_ENC;
                PH_LOW:    fin = ST_ENC;
                default:   fin = ST_OK;
            endcase
        end
        o_step.done_en          = i_last;
        o_step.done_item.status = fin;
        if (i_last) begin
            n_phase = PH_PREFIX;
            n_pos   = 3'd0;
            n_high  = 4'd0;
            n_err   = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PREFIX;
            r_pos   <= 3'd0;
            r_high  <= 4'd0;
            r_err   <= ST_OK;
        end else if (i_commit) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_high  <= n_high;
            r_err   <= n_err;
        end
    end

endmodule
`default_nettype wire

// ----- src/fupd_outq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fupd_outq
// small result queue taking up to two results per cycle, giving one per beat
// ----------------------------------------------------------------------------
module fupd_outq #(
    parameter int unsigned DEPTH = fupd_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire fupd_pkg::t_step i_step,
    output logic                o_room,
    output logic                o_valid,
    input  wire logic           i_ready,
    output fupd_pkg::t_res      o_res
);
    import fupd_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_res          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [PW-1:0] wr_done;
    logic          pop;
    logic [CW-1:0] n_in;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PW'(1);
        end
        return r;
    endfunction

    always_comb begin
        o_valid = (r_cnt != '0);
        o_res   = r_mem[r_rd];
        o_room  = (r_cnt <= CW'(DEPTH - 2));
        pop     = o_valid && i_ready;
        wr_done = i_step.byte_en ? ptr_inc(r_wr) : r_wr;
        n_in    = '0;
        n_wr    = r_wr;
        if (i_push) begin
            n_in = CW'(i_step.byte_en) + CW'(i_step.done_en);
            n_wr = i_step.done_en ? ptr_inc(wr_done) : wr_done;
        end
        n_rd  = pop ? ptr_inc(r_rd) : r_rd;
        n_cnt = r_cnt + n_in - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && i_step.byte_en) begin
            r_mem[r_wr] <= i_step.byte_res;
        end
        if (i_push && i_step.done_en) begin
            r_mem[wr_done] <= i_step.done_item;
        end
    end

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench of the file uri percent decoder: a table of directed
// beats, then random uri texts, mostly well-formed with random content and
// some with bad schemes, bad or cut-off escapes; every output beat is checked
// against a decoder model or a table status, with random idling on both streams
// ----------------------------------------------------------------------------
module tb;
    import fupd_pkg::*;

    typedef enum logic [1:0] {
        PH_SCHEME = 2'd0,
        PH_TEXT   = 2'd1,
        PH_ESC_HI = 2'd2,
        PH_ESC_LO = 2'd3
    } t_dec_phase;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       typed;
        t_status    status;
    } t_dir_row;

    localparam logic [55:0] SCHEME       = "file://";
    localparam int unsigned SCHEME_LEN   = 7;
    localparam int unsigned DIR_ROWS     = 25;
    localparam int unsigned RAND_ITEMS   = 1500;
    localparam int unsigned TAIL_CYCLES  = 10;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [7:0]  i_s_axis_tdata  = 8'h00;
    logic        i_s_axis_tlast  = 1'b0;
    logic        i_m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [15:0] o_m_axis_tdata;   // out_byte[7:0], status[9:8], zeros
    logic        o_m_axis_tlast;   // done_res
    logic        o_m_axis_tuser;   // byte_valid

    t_dec_phase  dec_phase = PH_SCHEME;
    logic [2:0]  dec_pos   = 3'd0;
    logic [3:0]  dec_hi    = 4'd0;
    t_status     dec_err   = ST_OK;

    t_res        decoded_q [$];
    logic [7:0]  uri_text [$];
    int unsigned send_idle_pct = 9;
    int unsigned recv_idle_pct = 53;
    int unsigned beats_sent    = 0;
    int unsigned mismatch_cnt  = 0;

    file_uri_percent_decoder_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    function automatic logic [7:0] scheme_char(input int unsigned p);
        return SCHEME[8 * (SCHEME_LEN - 1 - p) +: 8];
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

    function automatic int hex_digit_val(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return int'(c) - int'(8'h30);
        end
        if (c >= "a" && c <= "f") begin
            return int'(c) - int'(8'h61) + 10;
        end
        if (c >= "A" && c <= "F") begin
            return int'(c) - int'(8'h41) + 10;
        end
        return -1;
    endfunction

    task automatic decode_uri_byte(input logic [7:0] c, input logic last,
                                   output int unsigned n, output t_res r0, output t_res r1);
        t_res    res [2];
        int      h;
        t_status st;
        n = 0;
        res[0] = '0;
        res[1] = '0;
        h = hex_digit_val(c);
        if (dec_err == ST_OK) begin
            case (dec_phase)
                PH_SCHEME: begin
                    if (to_lower(c) != scheme_char(dec_pos)) begin
                        dec_err = ST_PROTO;
                    end else begin
                        dec_pos = dec_pos + 3'd1;
                        if (dec_pos == 3'(SCHEME_LEN)) begin
                            dec_phase = PH_TEXT;
                        end
                    end
                end
                PH_TEXT: begin
                    if (c == CHAR_PERCENT) begin
                        dec_phase = PH_ESC_HI;
                    end else begin
                        res[n] = '{out_byte: c, byte_valid: 1'b1, done_res: 1'b0, status: ST_OK};
                        n++;
                    end
                end
                PH_ESC_HI: begin
                    if (h < 0) begin
                        dec_err = ST_ENC;
                    end else begin
                        dec_hi = h[3:0];
                        dec_phase = PH_ESC_LO;
                    end
                end
                default: begin
                    if (h < 0) begin
                        dec_err = ST_ENC;
                    end else begin
                        res[n] = '{out_byte: {dec_hi, h[3:0]}, byte_valid: 1'b1,
                                   done_res: 1'b0, status: ST_OK};
                        n++;
                        dec_phase = PH_TEXT;
                    end
                end
            endcase
        end
        if (last) begin
            st = dec_err;
            if (st == ST_OK) begin
                if (dec_phase == PH_SCHEME) begin
                    st = ST_PROTO;
                end else if (dec_phase == PH_ESC_HI || dec_phase == PH_ESC_LO) begin
                    st = ST_ENC;
                end
            end
            res[n] = '{out_byte: 8'h00, byte_valid: 1'b0, done_res: 1'b1, status: st};
            n++;
            dec_phase = PH_SCHEME;
            dec_pos = 3'd0;
            dec_hi = 4'd0;
            dec_err = ST_OK;
        end
        r0 = res[0];
        r1 = res[1];
    endtask

    // drives one input beat, waits for its handshake and books its results
    task automatic send_beat(input logic [7:0] d, input logic last, input logic typed,
                             input t_status st);
        t_res        r0;
        t_res        r1;
        int unsigned n;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= d;
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        beats_sent++;
        decode_uri_byte(d, last, n, r0, r1);
        if (typed) begin
            decoded_q.push_back('{out_byte: 8'h00, byte_valid: 1'b0, done_res: 1'b1,
                                  status: st});
        end else begin
            if (n > 0) begin
                decoded_q.push_back(r0);
            end
            if (n > 1) begin
                decoded_q.push_back(r1);
            end
        end
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic add_hex_char(input logic [3:0] v);
        logic [7:0] c;
        if (v < 4'd10) begin
            c = 8'h30 + 8'(v);
        end else begin
            c = ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
        end
        uri_text.push_back(c);
    endtask

    task automatic add_scheme(input int unsigned len);
        logic [7:0] c;
        for (int unsigned p = 0; p < len; p++) begin
            c = scheme_char(p);
            if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z && $urandom_range(1)) begin
                c = c - CASE_OFFSET;
            end
            uri_text.push_back(c);
        end
    endtask

    task automatic add_body(input int unsigned len);
        logic [7:0] c;
        for (int unsigned k = 0; k < len; k++) begin
            if ($urandom_range(9) < 3) begin
                uri_text.push_back(CHAR_PERCENT);
                add_hex_char(4'($urandom_range(15)));
                add_hex_char(4'($urandom_range(15)));
            end else begin
                c = 8'($urandom_range(255));
                while (c == CHAR_PERCENT) begin
                    c = 8'($urandom_range(255));
                end
                uri_text.push_back(c);
            end
        end
    endtask

    task automatic add_noise(input int unsigned len);
        for (int unsigned k = 0; k < len; k++) begin
            uri_text.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic make_uri_text();
        int unsigned kind;
        int unsigned p;
        logic [7:0]  c;
        uri_text.delete();
        kind = $urandom_range(99);
        if (kind < 80) begin
            add_scheme(SCHEME_LEN);
            add_body($urandom_range(10));
        end else if (kind < 85) begin
            // scheme with one wrong byte
            p = $urandom_range(SCHEME_LEN - 1);
            add_scheme(p);
            c = 8'($urandom_range(255));
            while (to_lower(c) == scheme_char(p)) begin
                c = 8'($urandom_range(255));
            end
            uri_text.push_back(c);
            add_noise($urandom_range(4));
        end else if (kind < 89) begin
            // text ends inside the scheme
            add_scheme($urandom_range(1, SCHEME_LEN - 1));
        end else if (kind < 95) begin
            // bad escape digit, then ignored bytes
            add_scheme(SCHEME_LEN);
            add_body($urandom_range(4));
            uri_text.push_back(CHAR_PERCENT);
            if ($urandom_range(1)) begin
                add_hex_char(4'($urandom_range(15)));
            end
            c = 8'($urandom_range(255));
            while (hex_digit_val(c) >= 0) begin
                c = 8'($urandom_range(255));
            end
            uri_text.push_back(c);
            add_noise($urandom_range(3));
        end else begin
            // escape cut off by the end of text
            add_scheme(SCHEME_LEN);
            add_body($urandom_range(4));
            uri_text.push_back(CHAR_PERCENT);
            if ($urandom_range(1)) begin
                add_hex_char(4'($urandom_range(15)));
            end
        end
    endtask

    initial begin
        t_dir_row dir_tab [DIR_ROWS];
        dir_tab = '{
            '{8'hff, 1'b1, 1'b1, ST_PROTO},
            '{"f",   1'b0, 1'b0, ST_OK},
            '{"i",   1'b1, 1'b1, ST_PROTO},
            '{"F",   1'b0, 1'b0, ST_OK},
            '{"I",   1'b0, 1'b0, ST_OK},
            '{"L",   1'b0, 1'b0, ST_OK},
            '{"E",   1'b0, 1'b0, ST_OK},
            '{":",   1'b0, 1'b0, ST_OK},
            '{"/",   1'b0, 1'b0, ST_OK},
            '{"/",   1'b1, 1'b1, ST_OK},
            '{"f",   1'b0, 1'b0, ST_OK},
            '{"i",   1'b0, 1'b0, ST_OK},
            '{"l",   1'b0, 1'b0, ST_OK},
            '{"e",   1'b0, 1'b0, ST_OK},
            '{":",   1'b0, 1'b0, ST_OK},
            '{"/",   1'b0, 1'b0, ST_OK},
            '{"/",   1'b0, 1'b0, ST_OK},
            '{8'h00, 1'b0, 1'b0, ST_OK},
            '{"%",   1'b0, 1'b0, ST_OK},
            '{"a",   1'b0, 1'b0, ST_OK},
            '{"F",   1'b0, 1'b0, ST_OK},
            '{8'hff, 1'b0, 1'b0, ST_OK},
            '{"%",   1'b0, 1'b0, ST_OK},
            '{"g",   1'b0, 1'b0, ST_OK},
            '{"%",   1'b1, 1'b1, ST_ENC}
        };
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int unsigned r = 0; r < DIR_ROWS; r++) begin
            send_beat(dir_tab[r].data, dir_tab[r].last, dir_tab[r].typed, dir_tab[r].status);
        end
        drain_results();
        beats_sent = 0;
        for (int unsigned ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle_pct = 53;
                recv_idle_pct = 9;
            end else if (ph == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            while (beats_sent < RAND_ITEMS * (ph + 1) / 3) begin
                make_uri_text();
                for (int unsigned k = 0; k < uri_text.size(); k++) begin
                    send_beat(uri_text[k], k == uri_text.size() - 1, 1'b0, ST_OK);
                end
            end
            // hold the sender until every pending result is out
            drain_results();
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        t_res want;
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected output beat: data %h last %b user %b",
                           o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser);
                    mismatch_cnt++;
                end else begin
                    want = decoded_q.pop_front();
                    if (o_m_axis_tdata[7:0] !== want.out_byte) begin
                        $error("out_byte: expected %h, actual %h",
                               want.out_byte, o_m_axis_tdata[7:0]);
                        mismatch_cnt++;
                    end
                    if (o_m_axis_tuser !== want.byte_valid) begin
                        $error("byte_valid: expected %b, actual %b",
                               want.byte_valid, o_m_axis_tuser);
                        mismatch_cnt++;
                    end
                    if (o_m_axis_tlast !== want.done_res) begin
                        $error("done_res: expected %b, actual %b",
                               want.done_res, o_m_axis_tlast);
                        mismatch_cnt++;
                    end
                    if (o_m_axis_tdata[9:8] !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, o_m_axis_tdata[9:8]);
                        mismatch_cnt++;
                    end
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
